>>> hdl/cdsc_pkg.sv
// Package for the calendar day serial converter.
// Holds field widths, operation, option and error codes, the sequencer states
// and the month tables. Depends on nothing.
package cdsc_pkg;

    localparam int YEAR_W  = 12;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int SER_IO_W = 18;
    // Internal serial width covers every allowed pair of base and last year.
    localparam int SER_W   = 19;
    localparam int DOY_W   = 9;
    localparam int OP_W    = 2;
    localparam int OPT_W   = 3;
    localparam int ERR_W   = 3;

    // floor(p / 100) = (p * 5243) >> 19, exact for all 12-bit p.
    localparam int          REC100_W  = 13;
    localparam logic [12:0] REC100    = 13'd5243;
    localparam int          REC100_SH = 19;
    localparam int          Q100_W    = 6;

    // floor(x / 366) = (x * 733431) >> 28, exact for all 19-bit x.
    localparam int          REC366_W  = 20;
    localparam logic [19:0] REC366    = 20'd733431;
    localparam int          REC366_SH = 28;

    localparam logic [OP_W-1:0] OP_TO_SER   = 2'd0;
    localparam logic [OP_W-1:0] OP_FROM_SER = 2'd1;
    localparam logic [OP_W-1:0] OP_ROUND    = 2'd2;
    localparam logic [OP_W-1:0] OP_RSVD     = 2'd3;

    localparam logic [OPT_W-1:0] OPT_NONE       = 3'd0;
    localparam logic [OPT_W-1:0] OPT_FIRST      = 3'd1;
    localparam logic [OPT_W-1:0] OPT_FIRST_NEXT = 3'd2;
    localparam logic [OPT_W-1:0] OPT_LAST_THIS  = 3'd3;
    localparam logic [OPT_W-1:0] OPT_LAST_NEXT  = 3'd4;

    localparam logic [ERR_W-1:0] ERR_OK     = 3'd0;
    localparam logic [ERR_W-1:0] ERR_LOW    = 3'd1;
    localparam logic [ERR_W-1:0] ERR_HIGH   = 3'd2;
    localparam logic [ERR_W-1:0] ERR_DATE   = 3'd3;
    localparam logic [ERR_W-1:0] ERR_OPTION = 3'd4;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHK,
        S_FIXD,
        S_EST,
        S_JAN,
        S_YEAR,
        S_MONTH,
        S_SER,
        S_DONE
    } t_state;

    // Length of a month; months outside 1..12 read as 31 and are never used.
    function automatic logic [DAY_W-1:0] month_days(input logic leap,
                                                    input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] n;
        begin
            case (m)
                4'd2:    n = leap ? 5'd29 : 5'd28;
                4'd4:    n = 5'd30;
                4'd6:    n = 5'd30;
                4'd9:    n = 5'd30;
                4'd11:   n = 5'd30;
                default: n = 5'd31;
            endcase
            return n;
        end
    endfunction

    // Days in the months before month m of a common year.
    function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] m);
        logic [DOY_W-1:0] n;
        begin
            case (m)
                4'd2:    n = 9'd31;
                4'd3:    n = 9'd59;
                4'd4:    n = 9'd90;
                4'd5:    n = 9'd120;
                4'd6:    n = 9'd151;
                4'd7:    n = 9'd181;
                4'd8:    n = 9'd212;
                4'd9:    n = 9'd243;
                4'd10:   n = 9'd273;
                4'd11:   n = 9'd304;
                4'd12:   n = 9'd334;
                default: n = 9'd0;
            endcase
            return n;
        end
    endfunction

endpackage

>>> hdl/cdsc_yr_unit.sv
// Shared year unit: serial of January 1 of a year and its leap flag.
// Depends on cdsc_pkg.
module cdsc_yr_unit #(
    parameter int BASE_YEAR = 1875
) (
    input  logic [cdsc_pkg::YEAR_W-1:0] i_year,
    output logic [cdsc_pkg::SER_W-1:0]  o_jan1,
    output logic                        o_leap
);
    import cdsc_pkg::*;

    localparam int PB      = BASE_YEAR - 1;
    localparam int LB_BASE = PB / 4 - PB / 100 + PB / 400;

    logic [YEAR_W-1:0]            p;
    logic [YEAR_W+REC100_W-1:0]   prod100;
    logic [Q100_W-1:0]            q100;
    logic [YEAR_W-1:0]            r100;
    logic [YEAR_W-1:0]            lb;
    logic [SER_W-1:0]             yoff;
    logic [SER_W+8:0]             prod365;

    // Leap years below y are counted over p = y - 1.
    assign p       = i_year - YEAR_W'(1);
    assign prod100 = p * REC100;
    assign q100    = prod100[REC100_SH +: Q100_W];
    assign r100    = p - YEAR_W'({q100, 6'd0}) - YEAR_W'({q100, 5'd0})
                       - YEAR_W'({q100, 2'd0});
    assign lb      = YEAR_W'(p[YEAR_W-1:2]) - YEAR_W'(q100) + YEAR_W'(q100[Q100_W-1:2]);

    // y divisible by 4 when p ends in 3; by 100 when p mod 100 is 99,
    // and then by 400 when y / 100 = q100 + 1 is a multiple of four.
    assign o_leap  = (p[1:0] == 2'b11) &&
                     ((r100 != YEAR_W'(99)) || (q100[1:0] == 2'b11));

    assign yoff    = SER_W'(i_year) - SER_W'(BASE_YEAR);
    assign prod365 = yoff * 9'd365;
    assign o_jan1  = prod365[SER_W-1:0] + SER_W'(lb) - SER_W'(LB_BASE) + SER_W'(1);

endmodule

>>> hdl/calendar_day_serial_converter_top.sv
// Top level of the calendar day serial converter: request handshakes,
// sequencer and output register. Depends on cdsc_pkg and cdsc_yr_unit.
//
//  Channel | Handshake          | Payload
//  --------+--------------------+--------------------------------------------
//  input   | i_valid / o_ready  | opcode, year, month, day, serial, option
//  output  | o_valid / i_ready  | year, month, day, serial, error code
//
// One request is in work at a time; o_ready is high only while the sequencer
// is idle. A date to serial request runs through the check, serial and done
// states, a rounding request likewise with a month-length fix for some last
// day roundings, and a request refused at acceptance goes straight to done. A
// serial to date request runs the year estimate and its January 1, up to four
// year steps and up to eleven month steps, all through the one shared year unit.
// Reset is synchronous and active low; it clears the sequencer and o_valid.
// A result waits in the output register while o_valid is high and i_ready low;
// the next request is accepted meanwhile and stalls only in its done state.
module calendar_day_serial_converter_top #(
    parameter int BASE_YEAR = 1875,
    parameter int LAST_YEAR = 2250
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [cdsc_pkg::OP_W-1:0]      i_opcode,
    input  logic [cdsc_pkg::YEAR_W-1:0]    i_year_in,
    input  logic [cdsc_pkg::MONTH_W-1:0]   i_month_in,
    input  logic [cdsc_pkg::DAY_W-1:0]     i_day_in,
    input  logic [cdsc_pkg::SER_IO_W-1:0]  i_serial_in,
    input  logic [cdsc_pkg::OPT_W-1:0]     i_round_option,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [cdsc_pkg::YEAR_W-1:0]    o_year_out,
    output logic [cdsc_pkg::MONTH_W-1:0]   o_month_out,
    output logic [cdsc_pkg::DAY_W-1:0]     o_day_out,
    output logic [cdsc_pkg::SER_IO_W-1:0]  o_serial_out,
    output logic [cdsc_pkg::ERR_W-1:0]     o_error_code
);
    import cdsc_pkg::*;

    // Serial of the last representable day, LAST_YEAR-12-31.
    localparam int PB         = BASE_YEAR - 1;
    localparam int PL         = LAST_YEAR;
    localparam int MAX_SERIAL = (LAST_YEAR + 1 - BASE_YEAR) * 365
                                + (PL / 4 - PL / 100 + PL / 400)
                                - (PB / 4 - PB / 100 + PB / 400);

    localparam int EST_W = SER_W + REC366_W - REC366_SH;

    t_state               r_state, n_state;
    logic [OP_W-1:0]      r_op, n_op;
    logic [OPT_W-1:0]     r_opt, n_opt;
    logic [YEAR_W-1:0]    r_year, n_year;
    logic [MONTH_W-1:0]   r_month, n_month;
    logic [DAY_W-1:0]     r_day, n_day;
    logic [SER_W-1:0]     r_ser, n_ser;
    logic [SER_W-1:0]     r_jan1, n_jan1;
    logic [DOY_W-1:0]     r_rem, n_rem;
    logic [ERR_W-1:0]     r_err, n_err;

    logic                 r_out_valid, n_out_valid;
    logic [YEAR_W-1:0]    r_out_year, n_out_year;
    logic [MONTH_W-1:0]   r_out_month, n_out_month;
    logic [DAY_W-1:0]     r_out_day, n_out_day;
    logic [SER_IO_W-1:0]  r_out_ser, n_out_ser;
    logic [ERR_W-1:0]     r_out_err, n_out_err;

    // Shared year unit and its operand select.
    logic [YEAR_W-1:0]    u_year;
    logic [SER_W-1:0]     u_jan1;
    logic                 u_leap;

    logic                 in_acc;
    logic [DAY_W-1:0]     md;
    logic                 nm_ok;
    logic [YEAR_W-1:0]    nm_year;
    logic [MONTH_W-1:0]   nm_month;
    logic [SER_W+REC366_W-1:0] est_prod;
    logic [EST_W-1:0]     est_q;
    logic [SER_W-1:0]     doy_full;

    cdsc_yr_unit #(
        .BASE_YEAR (BASE_YEAR)
    ) u_yr (
        .i_year (u_year),
        .o_jan1 (u_jan1),
        .o_leap (u_leap)
    );

    // During the year search the unit looks one year ahead; otherwise it
    // works on the current year.
    always_comb begin
        if (r_state == S_YEAR) begin
            u_year = r_year + YEAR_W'(1);
        end else begin
            u_year = r_year;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign in_acc  = i_valid && o_ready;

    // Month length of the current month in the year seen by the unit.
    assign md = month_days(u_leap, r_month);

    // Step to the next month; fails past December of the last year.
    assign nm_ok    = !((r_month == MONTH_DEC) && (r_year >= YEAR_W'(LAST_YEAR)));
    assign nm_year  = (r_month == MONTH_DEC) ? r_year + YEAR_W'(1) : r_year;
    assign nm_month = (r_month == MONTH_DEC) ? MONTH_JAN : r_month + MONTH_W'(1);

    // Year estimate BASE_YEAR + (s - 1) / 366 never overshoots the true year.
    assign est_prod = (r_ser - SER_W'(1)) * REC366;
    assign est_q    = est_prod[SER_W+REC366_W-1:REC366_SH];

    // Day of the year once the year search has settled.
    assign doy_full = r_ser - r_jan1 + SER_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_opt       <= n_opt;
        r_year      <= n_year;
        r_month     <= n_month;
        r_day       <= n_day;
        r_ser       <= n_ser;
        r_jan1      <= n_jan1;
        r_rem       <= n_rem;
        r_err       <= n_err;
        r_out_year  <= n_out_year;
        r_out_month <= n_out_month;
        r_out_day   <= n_out_day;
        r_out_ser   <= n_out_ser;
        r_out_err   <= n_out_err;
    end

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_opt       = r_opt;
        n_year      = r_year;
        n_month     = r_month;
        n_day       = r_day;
        n_ser       = r_ser;
        n_jan1      = r_jan1;
        n_rem       = r_rem;
        n_err       = r_err;
        n_out_valid = r_out_valid && !i_ready;
        n_out_year  = r_out_year;
        n_out_month = r_out_month;
        n_out_day   = r_out_day;
        n_out_ser   = r_out_ser;
        n_out_err   = r_out_err;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_op    = i_opcode;
                    n_opt   = i_round_option;
                    n_year  = i_year_in;
                    n_month = i_month_in;
                    n_day   = i_day_in;
                    n_ser   = SER_W'(i_serial_in);
                    n_err   = ERR_OK;
                    case (i_opcode)
                        OP_TO_SER: begin
                            n_state = S_CHK;
                        end
                        OP_ROUND: begin
                            // The option is checked before the date.
                            if (i_round_option > OPT_LAST_NEXT) begin
                                n_err   = ERR_OPTION;
                                n_state = S_DONE;
                            end else begin
                                n_state = S_CHK;
                            end
                        end
                        OP_FROM_SER: begin
                            if (i_serial_in == '0) begin
                                n_err   = ERR_LOW;
                                n_state = S_DONE;
                            end else if (SER_W'(i_serial_in) > SER_W'(MAX_SERIAL)) begin
                                n_err   = ERR_HIGH;
                                n_state = S_DONE;
                            end else begin
                                n_state = S_EST;
                            end
                        end
                        default: begin
                            n_err   = ERR_OPTION;
                            n_state = S_DONE;
                        end
                    endcase
                end
            end

            S_CHK: begin
                // Range first, then month and day; rounding only on a good date.
                if (r_year < YEAR_W'(BASE_YEAR)) begin
                    n_err   = ERR_LOW;
                    n_state = S_DONE;
                end else if (r_year > YEAR_W'(LAST_YEAR)) begin
                    n_err   = ERR_HIGH;
                    n_state = S_DONE;
                end else if ((r_month < MONTH_JAN) || (r_month > MONTH_DEC) ||
                             (r_day == '0) || (r_day > md)) begin
                    n_err   = ERR_DATE;
                    n_state = S_DONE;
                end else if (r_op == OP_ROUND) begin
                    n_state = S_SER;
                    case (r_opt)
                        OPT_FIRST, OPT_FIRST_NEXT: begin
                            if ((r_opt == OPT_FIRST_NEXT) || (r_day != DAY_W'(1))) begin
                                if (nm_ok) begin
                                    n_year  = nm_year;
                                    n_month = nm_month;
                                    n_day   = DAY_W'(1);
                                end else begin
                                    n_err   = ERR_HIGH;
                                    n_state = S_DONE;
                                end
                            end
                        end
                        OPT_LAST_THIS: begin
                            n_day = md;
                        end
                        OPT_LAST_NEXT: begin
                            if (r_day == md) begin
                                // The new month's length needs the new year's
                                // leap flag, taken in the next state, S_FIXD.
                                if (nm_ok) begin
                                    n_year  = nm_year;
                                    n_month = nm_month;
                                    n_state = S_FIXD;
                                end else begin
                                    n_err   = ERR_HIGH;
                                    n_state = S_DONE;
                                end
                            end else begin
                                n_day = md;
                            end
                        end
                        default: begin
                            n_state = S_SER;
                        end
                    endcase
                end else begin
                    n_state = S_SER;
                end
            end

            S_FIXD: begin
                n_day   = md;
                n_state = S_SER;
            end

            S_EST: begin
                n_year  = YEAR_W'(BASE_YEAR) + YEAR_W'(est_q);
                n_state = S_JAN;
            end

            S_JAN: begin
                n_jan1  = u_jan1;
                n_state = S_YEAR;
            end

            S_YEAR: begin
                // Advance while the next year still starts at or before s.
                if ((r_year < YEAR_W'(LAST_YEAR)) && (u_jan1 <= r_ser)) begin
                    n_year = r_year + YEAR_W'(1);
                    n_jan1 = u_jan1;
                end else begin
                    n_rem   = doy_full[DOY_W-1:0];
                    n_month = MONTH_JAN;
                    n_state = S_MONTH;
                end
            end

            S_MONTH: begin
                if ((r_month < MONTH_DEC) && (r_rem > DOY_W'(md))) begin
                    n_rem   = r_rem - DOY_W'(md);
                    n_month = r_month + MONTH_W'(1);
                end else begin
                    n_day   = r_rem[DAY_W-1:0];
                    n_state = S_SER;
                end
            end

            S_SER: begin
                n_ser = u_jan1 - SER_W'(1) + SER_W'(days_before(r_month))
                        + SER_W'(u_leap && (r_month > MONTH_FEB)) + SER_W'(r_day);
                n_state = S_DONE;
            end

            S_DONE: begin
                // Load the output register once it is free or being emptied.
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_out_err   = r_err;
                    if (r_err != ERR_OK) begin
                        n_out_year  = '0;
                        n_out_month = '0;
                        n_out_day   = '0;
                        n_out_ser   = '0;
                    end else begin
                        n_out_year  = r_year;
                        n_out_month = r_month;
                        n_out_day   = r_day;
                        n_out_ser   = r_ser[SER_IO_W-1:0];
                    end
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_valid      = r_out_valid;
    assign o_year_out   = r_out_year;
    assign o_month_out  = r_out_month;
    assign o_day_out    = r_out_day;
    assign o_serial_out = r_out_ser;
    assign o_error_code = r_out_err;

    // An error result carries an all-zero date and serial.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_error_code != ERR_OK)) |->
            ((o_year_out == '0) && (o_month_out == '0) && (o_day_out == '0) &&
             (o_serial_out == '0)))
        else $error("error result with nonzero fields");

    // A good result is a real date with a nonzero serial.
    a_ok_date: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_error_code == ERR_OK)) |->
            ((o_month_out >= MONTH_JAN) && (o_month_out <= MONTH_DEC) &&
             (o_day_out != '0) && (o_serial_out != '0)))
        else $error("good result is not a valid date");

    // The year estimate never passes the last year during the search.
    a_year_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_YEAR) |-> (r_year <= YEAR_W'(LAST_YEAR)))
        else $error("year search beyond last year");

    // The month search stays within the year.
    a_month_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MONTH) |-> ((r_month >= MONTH_JAN) && (r_month <= MONTH_DEC)))
        else $error("month search out of range");

    // An accepted request keeps the input side closed in the next cycle.
    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_ready)
        else $error("second request accepted while one is in work");

endmodule

>>> tb/calendar_day_serial_converter_top_tb.sv
// Testbench for calendar_day_serial_converter_top: directed and random requests
// for all three conversions and the reserved opcode, checked against a predictor.
// Depends on cdsc_pkg and the RTL of the converter; reads no files.
`timescale 1ns / 1ps

module calendar_day_serial_converter_top_tb;

    import cdsc_pkg::*;

    // The calendar span the block is built for. Day 1 is the first of January
    // of BASE_YEAR and the last valid day is the last of December of LAST_YEAR.
    localparam int unsigned BASE_YEAR = 1875;
    localparam int unsigned LAST_YEAR = 2250;

    // Number of random requests after the directed part.
    localparam int unsigned RANDOM_REQUESTS = 1850;

    // One request as it stands on the input channel.
    typedef struct {
        logic [OP_W-1:0]     op;
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [SER_IO_W-1:0] serial;
        logic [OPT_W-1:0]    option;
    } t_date_req;

    // One result as it stands on the output channel.
    typedef struct {
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [SER_IO_W-1:0] serial;
        logic [ERR_W-1:0]    err;
    } t_date_res;

    // The scoreboard works out the calendar answer for every accepted request
    // and keeps the answers in order until the block hands back its results.
    class t_day_serial_scoreboard;
        t_date_res   pending_dates[$];
        int unsigned mismatches;
        int unsigned requests_noted;
        int unsigned results_checked;
        int unsigned per_opcode[4];
        int unsigned per_error[8];

        function bit leap_year(int unsigned y);
            return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
        endfunction

        // Month length; only called with m in 1..12.
        function int unsigned month_len(int unsigned y, int unsigned m);
            case (m)
                2:           return leap_year(y) ? 29 : 28;
                4, 6, 9, 11: return 30;
                default:     return 31;
            endcase
        endfunction

        // Days in the months ahead of month m in a common year.
        function int unsigned days_ahead(int unsigned m);
            int unsigned total;
            total = 0;
            for (int unsigned k = 1; k < m; k++) begin
                total += month_len(1, k);
            end
            return total;
        endfunction

        // Leap years in 1..p.
        function int unsigned leaps_through(int unsigned p);
            return p / 4 - p / 100 + p / 400;
        endfunction

        // Serial of a date; the year search calls it for y + 1 only while y is below LAST_YEAR.
        function int unsigned day_number(int unsigned y, int unsigned m, int unsigned d);
            int unsigned n;
            n = (y - BASE_YEAR) * 365 + leaps_through(y - 1) - leaps_through(BASE_YEAR - 1)
                + days_ahead(m) + d;
            if (leap_year(y) && m > 2) begin
                n += 1;
            end
            return n;
        endfunction

        function int unsigned last_serial();
            return day_number(LAST_YEAR, 32'(MONTH_DEC), 31);
        endfunction

        // Year first from a low estimate, then month by month.
        function void split_serial(int unsigned s, output int unsigned y,
                                   output int unsigned m, output int unsigned d);
            int unsigned rem;
            y = BASE_YEAR + (s - 1) / 366;
            while (y < LAST_YEAR && day_number(y + 1, 32'(MONTH_JAN), 1) <= s) begin
                y++;
            end
            rem = s - day_number(y, 32'(MONTH_JAN), 1) + 1;
            m = 1;
            while (m < 12 && rem > month_len(y, m)) begin
                rem -= month_len(y, m);
                m++;
            end
            d = rem;
        endfunction

        // Range of the year first, then the shape of the date.
        function logic [ERR_W-1:0] validate_date(int unsigned y, int unsigned m,
                                                 int unsigned d);
            if (y < BASE_YEAR) begin
                return ERR_LOW;
            end
            if (y > LAST_YEAR) begin
                return ERR_HIGH;
            end
            if (m < 1 || m > 12 || d < 1 || d > month_len(y, m)) begin
                return ERR_DATE;
            end
            return ERR_OK;
        endfunction

        // Moves to the next month; returns 0 when that would leave the span.
        function bit step_month(inout int unsigned y, inout int unsigned m);
            if (m == 32'(MONTH_DEC)) begin
                if (y >= LAST_YEAR) begin
                    return 1'b0;
                end
                y++;
                m = 32'(MONTH_JAN);
            end else begin
                m++;
            end
            return 1'b1;
        endfunction

        function t_date_res predict_date(t_date_req r);
            int unsigned      y, m, d;
            logic [ERR_W-1:0] err;
            t_date_res        res;
            y   = 32'(r.year);
            m   = 32'(r.month);
            d   = 32'(r.day);
            err = ERR_OK;
            case (r.op)
                OP_TO_SER: begin
                    err = validate_date(y, m, d);
                end
                OP_FROM_SER: begin
                    if (r.serial == '0) begin
                        err = ERR_LOW;
                    end else if (32'(r.serial) > last_serial()) begin
                        err = ERR_HIGH;
                    end else begin
                        split_serial(32'(r.serial), y, m, d);
                    end
                end
                OP_ROUND: begin
                    // A bad option wins over a bad date.
                    if (r.option > OPT_LAST_NEXT) begin
                        err = ERR_OPTION;
                    end else begin
                        err = validate_date(y, m, d);
                    end
                    if (err == ERR_OK) begin
                        if (r.option == OPT_FIRST_NEXT ||
                            (r.option == OPT_FIRST && d != 1)) begin
                            if (step_month(y, m)) begin
                                d = 1;
                            end else begin
                                err = ERR_HIGH;
                            end
                        end else if (r.option == OPT_LAST_THIS) begin
                            d = month_len(y, m);
                        end else if (r.option == OPT_LAST_NEXT) begin
                            if (d != month_len(y, m)) begin
                                d = month_len(y, m);
                            end else if (step_month(y, m)) begin
                                d = month_len(y, m);
                            end else begin
                                err = ERR_HIGH;
                            end
                        end
                    end
                end
                default: begin
                    err = ERR_OPTION;
                end
            endcase
            if (err != ERR_OK) begin
                res.year   = '0;
                res.month  = '0;
                res.day    = '0;
                res.serial = '0;
            end else begin
                res.year   = YEAR_W'(y);
                res.month  = MONTH_W'(m);
                res.day    = DAY_W'(d);
                res.serial = SER_IO_W'(day_number(y, m, d));
            end
            res.err = err;
            return res;
        endfunction

        function void note_request(t_date_req r);
            pending_dates.push_back(predict_date(r));
            requests_noted++;
            per_opcode[r.op]++;
        endfunction

        task report_mismatch(string what);
            $display("[%0t] mismatch: %s", $time, what);
            mismatches++;
        endtask

        task check_result(t_date_res got);
            t_date_res want;
            results_checked++;
            per_error[got.err]++;
            if (pending_dates.size() == 0) begin
                report_mismatch("result arrived with no request outstanding");
            end else begin
                want = pending_dates.pop_front();
                if (got.year !== want.year)
                    report_mismatch($sformatf("year %0d, expected %0d", got.year, want.year));
                if (got.month !== want.month)
                    report_mismatch($sformatf("month %0d, expected %0d", got.month, want.month));
                if (got.day !== want.day)
                    report_mismatch($sformatf("day %0d, expected %0d", got.day, want.day));
                if (got.serial !== want.serial)
                    report_mismatch($sformatf("serial %0d, expected %0d",
                                              got.serial, want.serial));
                if (got.err !== want.err)
                    report_mismatch($sformatf("error code %0d, expected %0d",
                                              got.err, want.err));
            end
        endtask
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    logic [OP_W-1:0]     i_opcode;
    logic [YEAR_W-1:0]   i_year_in;
    logic [MONTH_W-1:0]  i_month_in;
    logic [DAY_W-1:0]    i_day_in;
    logic [SER_IO_W-1:0] i_serial_in;
    logic [OPT_W-1:0]    i_round_option;
    logic                o_valid;
    logic                i_ready;
    logic [YEAR_W-1:0]   o_year_out;
    logic [MONTH_W-1:0]  o_month_out;
    logic [DAY_W-1:0]    o_day_out;
    logic [SER_IO_W-1:0] o_serial_out;
    logic [ERR_W-1:0]    o_error_code;

    t_day_serial_scoreboard sb = new();
    int unsigned            sent_count;
    int unsigned            taken_count;

    calendar_day_serial_converter_top #(
        .BASE_YEAR(BASE_YEAR),
        .LAST_YEAR(LAST_YEAR)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_opcode      (i_opcode),
        .i_year_in     (i_year_in),
        .i_month_in    (i_month_in),
        .i_day_in      (i_day_in),
        .i_serial_in   (i_serial_in),
        .i_round_option(i_round_option),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_year_out    (o_year_out),
        .o_month_out   (o_month_out),
        .o_day_out     (o_day_out),
        .o_serial_out  (o_serial_out),
        .o_error_code  (o_error_code)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // The slowest correct run is about 1900 requests, each with its longest
    // idle gap, its work and its longest result stall; five milliseconds is
    // far beyond that.
    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic t_date_req make_request(logic [OP_W-1:0] op, int unsigned y,
                                               int unsigned m, int unsigned d,
                                               int unsigned s, logic [OPT_W-1:0] opt);
        t_date_req r;
        r.op     = op;
        r.year   = YEAR_W'(y);
        r.month  = MONTH_W'(m);
        r.day    = DAY_W'(d);
        r.serial = SER_IO_W'(s);
        r.option = opt;
        return r;
    endfunction

    // Random requests lean toward well-formed dates and serials inside the
    // span, with the edges of the span weighted up, and keep a share of
    // arbitrary field values so that every input bit is exercised.
    function automatic t_date_req random_request();
        t_date_req   r;
        int unsigned pick, lim, top;
        pick = $urandom_range(0, 99);
        if (pick < 35)      r.op = OP_TO_SER;
        else if (pick < 65) r.op = OP_FROM_SER;
        else if (pick < 95) r.op = OP_ROUND;
        else                r.op = OP_RSVD;

        pick = $urandom_range(0, 9);
        if (pick == 0)      r.year = YEAR_W'(LAST_YEAR);
        else if (pick == 1) r.year = YEAR_W'(BASE_YEAR);
        else if (pick < 8)  r.year = YEAR_W'($urandom_range(BASE_YEAR, LAST_YEAR));
        else                r.year = YEAR_W'($urandom_range(0, 4095));

        if ($urandom_range(0, 9) < 9) r.month = MONTH_W'($urandom_range(1, 12));
        else                          r.month = MONTH_W'($urandom_range(0, 15));

        lim  = (r.month >= 1 && r.month <= 12) ?
               sb.month_len(32'(r.year), 32'(r.month)) : 31;
        pick = $urandom_range(0, 9);
        if (pick == 0)      r.day = DAY_W'(1);
        else if (pick < 3)  r.day = DAY_W'(lim);
        else if (pick < 8)  r.day = DAY_W'($urandom_range(1, lim));
        else                r.day = DAY_W'($urandom_range(0, 31));

        top  = sb.last_serial();
        pick = $urandom_range(0, 9);
        if (pick == 0)      r.serial = SER_IO_W'($urandom_range(top - 400, top + 5));
        else if (pick == 1) r.serial = SER_IO_W'($urandom_range(0, 400));
        else if (pick < 8)  r.serial = SER_IO_W'($urandom_range(1, top));
        else                r.serial = SER_IO_W'($urandom_range(0, 262143));

        if ($urandom_range(0, 99) < 88) r.option = OPT_W'($urandom_range(0, 4));
        else                            r.option = OPT_W'($urandom_range(5, 7));
        return r;
    endfunction

    // Offers one request after an idle gap and holds it until the block
    // takes it. Valid and payload get one assignment each per edge, so a
    // zero gap keeps valid high straight into the next request.
    task automatic send_request(t_date_req r, int unsigned gap);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_opcode       <= r.op;
        i_year_in      <= r.year;
        i_month_in     <= r.month;
        i_day_in       <= r.day;
        i_serial_in    <= r.serial;
        i_round_option <= r.option;
        do @(posedge i_clk); while (!o_ready);
        sb.note_request(r);
        sent_count++;
    endtask

    // Holds off new requests until every outstanding result is back.
    task automatic wait_for_drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending_dates.size() != 0);
    endtask

    // Every fourth block of 64 requests goes out back to back; the rest get
    // random gaps so that idle cycles land on every phase of the work.
    function automatic int unsigned sender_gap();
        if ((sent_count / 64) % 4 == 3) begin
            return 0;
        end
        return $urandom_range(0, 7);
    endfunction

    // Result side: random stalls, with stall-free stretches on a different
    // period from the sender so that both quiet and busy overlaps happen.
    initial begin
        int unsigned stall;
        t_date_res   got;
        i_ready     <= 1'b0;
        taken_count = 0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = ((taken_count / 48) % 4 == 1) ? 0 : $urandom_range(0, 7);
            if (stall != 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            got.year   = o_year_out;
            got.month  = o_month_out;
            got.day    = o_day_out;
            got.serial = o_serial_out;
            got.err    = o_error_code;
            sb.check_result(got);
            taken_count++;
        end
    end

    // Request side: reset, the directed list, then the random stream with a
    // full drain now and then, then the final wait and the verdict.
    initial begin
        t_date_req   directed[$];
        int unsigned top;
        sent_count     = 0;
        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_opcode       <= OP_TO_SER;
        i_year_in      <= '0;
        i_month_in     <= '0;
        i_day_in       <= '0;
        i_serial_in    <= '0;
        i_round_option <= OPT_NONE;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        top = sb.last_serial();
        // Both ends of the span, years just outside it and all-zero and
        // all-one fields, which hit the low and high range errors.
        directed.push_back(make_request(OP_TO_SER, BASE_YEAR, 1, 1, 262143, OPT_NONE));
        directed.push_back(make_request(OP_TO_SER, LAST_YEAR, 12, 31, 0, 3'd7));
        directed.push_back(make_request(OP_TO_SER, BASE_YEAR - 1, 12, 31, 0, OPT_NONE));
        directed.push_back(make_request(OP_TO_SER, LAST_YEAR + 1, 1, 1, 0, OPT_NONE));
        directed.push_back(make_request(OP_TO_SER, 0, 0, 0, 0, OPT_NONE));
        directed.push_back(make_request(OP_TO_SER, 4095, 15, 31, 262143, 3'd7));
        // Leap rule: divisible by 400 is leap, by 100 alone is not.
        directed.push_back(make_request(OP_TO_SER, 2000, 2, 29, 0, OPT_NONE));
        directed.push_back(make_request(OP_TO_SER, 1900, 2, 29, 0, OPT_NONE));
        // Malformed dates inside the span: month past December, month zero,
        // day zero and a day beyond a 30-day month.
        directed.push_back(make_request(OP_TO_SER, 2000, 13, 1, 0, OPT_NONE));
        directed.push_back(make_request(OP_TO_SER, 2000, 0, 10, 0, OPT_NONE));
        directed.push_back(make_request(OP_TO_SER, 2000, 4, 0, 0, OPT_NONE));
        directed.push_back(make_request(OP_TO_SER, 2000, 4, 31, 0, OPT_NONE));
        // Serial to date: zero, first day, last day, one past it, all ones.
        directed.push_back(make_request(OP_FROM_SER, 0, 0, 0, 0, OPT_NONE));
        directed.push_back(make_request(OP_FROM_SER, 4095, 15, 31, 1, 3'd7));
        directed.push_back(make_request(OP_FROM_SER, 0, 0, 0, top, OPT_NONE));
        directed.push_back(make_request(OP_FROM_SER, 0, 0, 0, top + 1, OPT_NONE));
        directed.push_back(make_request(OP_FROM_SER, 0, 0, 0, 262143, OPT_NONE));
        // Rounding: a bad option is reported even for a bad date, then each
        // option, including rounding that would run past the last day.
        directed.push_back(make_request(OP_ROUND, 0, 0, 0, 0, 3'd5));
        directed.push_back(make_request(OP_ROUND, 2024, 5, 17, 0, OPT_NONE));
        directed.push_back(make_request(OP_ROUND, 2024, 5, 1, 0, OPT_FIRST));
        directed.push_back(make_request(OP_ROUND, 2024, 5, 17, 0, OPT_FIRST));
        directed.push_back(make_request(OP_ROUND, 2024, 12, 1, 0, OPT_FIRST_NEXT));
        directed.push_back(make_request(OP_ROUND, 2024, 2, 10, 0, OPT_LAST_THIS));
        directed.push_back(make_request(OP_ROUND, 2024, 1, 31, 0, OPT_LAST_NEXT));
        directed.push_back(make_request(OP_ROUND, LAST_YEAR, 12, 5, 0, OPT_FIRST_NEXT));
        directed.push_back(make_request(OP_ROUND, LAST_YEAR, 12, 31, 0, OPT_LAST_NEXT));
        directed.push_back(make_request(OP_RSVD, 2000, 6, 15, 500, OPT_NONE));

        foreach (directed[k]) begin
            send_request(directed[k], $urandom_range(0, 7));
        end
        wait_for_drain();

        for (int unsigned k = 0; k < RANDOM_REQUESTS; k++) begin
            send_request(random_request(), sender_gap());
            if (k % 300 == 299) begin
                wait_for_drain();
            end
        end

        // Last request is in; wait for every result, then keep watching the
        // output to show any result the block should not send.
        wait_for_drain();
        repeat (40) @(posedge i_clk);

        $display("Ran %0d requests: %0d date to serial, %0d serial to date,",
                 sb.requests_noted, sb.per_opcode[OP_TO_SER], sb.per_opcode[OP_FROM_SER]);
        $display("  %0d round up, %0d reserved.",
                 sb.per_opcode[OP_ROUND], sb.per_opcode[OP_RSVD]);
        $display("Results seen: %0d ok, %0d below, %0d above, %0d bad date,",
                 sb.per_error[ERR_OK], sb.per_error[ERR_LOW], sb.per_error[ERR_HIGH],
                 sb.per_error[ERR_DATE]);
        $display("  %0d bad option; %0d mismatches.",
                 sb.per_error[ERR_OPTION], sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
